>>> rtl/stmva_pkg.sv
// Shared constants for the sparse transpose matrix-vector accumulate block.
package stmva_pkg;

   localparam int VECTOR_DEPTH = 1024;
   localparam int VEC_AW       = $clog2(VECTOR_DEPTH);
   localparam int INDEX_W      = 10;
   localparam int IDX_EXT_W    = 17;
   localparam int DATA_W       = 32;
   localparam int ACC_W        = 64;
   localparam int FRAC_W       = 16;
   localparam int COL_W        = 10;
   localparam int CSR_IDX_W    = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_ADD_MODE        = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_FROM_ZERO = 1'b1;

   localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

endpackage

>>> rtl/stmva_ram.sv
// Generic single-port synchronous RAM with registered read and read enable.
module stmva_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic             re,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/sparse_transpose_matvec_accumulate.sv
// Top level: sparse matrix-transpose times vector, accumulated per column.
//
// Usage:
//   req_*  : one request per accepted valid/ready handshake. func 0 writes
//            entry_value into the vector store at index; func 1 is one column
//            item (a nonzero at row index, or an empty marker when has_entry
//            is 0), with column_start / column_end framing each column.
//   rsp_*  : one response per request with func 1 and column_end set,
//            carrying the floored, saturated Q16.16 column value, the running
//            column number and the clip flag.
//   csr_*  : register writes (add_mode, start_from_zero), always ready; write
//            them only while no request is in flight.
// Timing: one request per cycle while req_ready is high. A response passes the
//   store read, multiply, accumulate, then the output register after its last
//   request is accepted. A store write is seen by a request accepted the next cycle.
// Reset: synchronous; clears the pipeline, accumulator, column counter and
//   registers. The vector store is not cleared; write it before use.
// Stall: requests keep flowing while a response waits; the pipeline holds
//   (req_ready low) only when a second finished column reaches the output
//   while the first is still not taken.
module sparse_transpose_matvec_accumulate (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_func,
   input  logic [stmva_pkg::INDEX_W-1:0]        req_index,
   input  logic signed [stmva_pkg::DATA_W-1:0]  req_entry_value,
   input  logic                                 req_has_entry,
   input  logic                                 req_column_start,
   input  logic                                 req_column_end,
   input  logic signed [stmva_pkg::DATA_W-1:0]  req_initial_y,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [stmva_pkg::DATA_W-1:0]  rsp_y_value,
   output logic [stmva_pkg::COL_W-1:0]          rsp_column_number,
   output logic                                 rsp_saturated,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [stmva_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic                                 csr_wdata
);

   import stmva_pkg::*;

   logic                     advance;
   logic                     accept;
   logic [IDX_EXT_W-1:0]     idx_ext;
   logic                     in_range;
   logic [DATA_W-1:0]        ram_rdata;

   logic                     add_mode_ff;
   logic                     start_zero_ff;

   logic                     s1_valid_ff;
   logic                     s1_in_range_ff;
   logic                     s1_has_ff;
   logic                     s1_start_ff;
   logic                     s1_end_ff;
   logic signed [DATA_W-1:0] s1_val_ff;
   logic signed [DATA_W-1:0] s1_init_ff;
   logic signed [DATA_W-1:0] s1_x;

   logic                     s2_valid_ff;
   logic                     s2_has_ff;
   logic                     s2_start_ff;
   logic                     s2_end_ff;
   logic signed [ACC_W-1:0]  s2_prod_ff;
   logic signed [ACC_W-1:0]  s2_prod_in;
   logic signed [DATA_W-1:0] s2_init_ff;

   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic                     clip_ff;
   logic                     clip_in;
   logic [COL_W-1:0]         col_ff;
   logic [COL_W-1:0]         col_in;
   logic signed [ACC_W-1:0]  acc_base;
   logic signed [ACC_W-1:0]  addend;
   logic signed [ACC_W-1:0]  acc_sum;
   logic signed [ACC_W-1:0]  acc_new;
   logic                     ovf_pos;
   logic                     ovf_neg;
   logic                     clip_new;

   logic                     fin_valid_ff;
   logic signed [ACC_W-1:0]  fin_acc_ff;
   logic                     fin_clip_ff;
   logic [COL_W-1:0]         fin_col_ff;
   logic                     fits;
   logic signed [DATA_W-1:0] y_sat;

   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_y_ff;
   logic [COL_W-1:0]         rsp_col_ff;
   logic                     rsp_sat_ff;
   logic                     out_load;

   // hold only when a finished column cannot enter the full output register
   assign advance   = ~(fin_valid_ff & rsp_valid_ff & ~rsp_ready);
   assign req_ready = advance;
   assign accept    = req_valid & advance;
   assign csr_ready = 1'b1;

   assign idx_ext  = {{(IDX_EXT_W-INDEX_W){1'b0}}, req_index};
   assign in_range = idx_ext < IDX_EXT_W'(VECTOR_DEPTH);

   stmva_ram #(
      .WIDTH (DATA_W),
      .DEPTH (VECTOR_DEPTH)
   ) u_vec_ram (
      .clock (clock),
      .we    (accept & ~req_func & in_range),
      .re    (advance),
      .addr  (idx_ext[VEC_AW-1:0]),
      .wdata (req_entry_value),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         add_mode_ff   <= 1'b0;
         start_zero_ff <= 1'b0;
      end else if (csr_valid & csr_ready) begin
         case (csr_index)
            CSR_ADD_MODE:        add_mode_ff   <= csr_wdata;
            CSR_START_FROM_ZERO: start_zero_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage 1: store read in flight; multiply by the stored value
   assign s1_x       = s1_in_range_ff ? $signed(ram_rdata) : '0;
   assign s2_prod_in = $signed({{(ACC_W-DATA_W){s1_val_ff[DATA_W-1]}}, s1_val_ff})
                     * $signed({{(ACC_W-DATA_W){s1_x[DATA_W-1]}}, s1_x});

   // stage 2: accumulate
   always_comb begin
      if (s2_start_ff) begin
         acc_base = start_zero_ff ? '0
                  : {{(ACC_W-DATA_W-FRAC_W){s2_init_ff[DATA_W-1]}}, s2_init_ff,
                     {FRAC_W{1'b0}}};
      end else begin
         acc_base = acc_ff;
      end
      if (!s2_has_ff) begin
         addend = '0;
      end else if (add_mode_ff) begin
         addend = s2_prod_ff;
      end else begin
         addend = -s2_prod_ff;
      end
      acc_sum = acc_base + addend;
      ovf_pos = ~acc_base[ACC_W-1] & ~addend[ACC_W-1] & acc_sum[ACC_W-1];
      ovf_neg = acc_base[ACC_W-1] & addend[ACC_W-1] & ~acc_sum[ACC_W-1];
      if (ovf_pos) begin
         acc_new = {1'b0, {(ACC_W-1){1'b1}}};
      end else if (ovf_neg) begin
         acc_new = {1'b1, {(ACC_W-1){1'b0}}};
      end else begin
         acc_new = acc_sum;
      end
      clip_new = ((~s2_start_ff) & clip_ff) | ovf_pos | ovf_neg;

      acc_in  = acc_ff;
      clip_in = clip_ff;
      col_in  = col_ff;
      if (advance & s2_valid_ff) begin
         if (s2_end_ff) begin
            acc_in  = '0;
            clip_in = 1'b0;
            col_in  = col_ff + 1'b1;
         end else begin
            acc_in  = acc_new;
            clip_in = clip_new;
         end
      end
   end

   // floor to Q16.16 and clip to 32 bits
   always_comb begin
      fits = (&fin_acc_ff[ACC_W-1:DATA_W+FRAC_W-1]) |
             (~|fin_acc_ff[ACC_W-1:DATA_W+FRAC_W-1]);
      if (fits) begin
         y_sat = fin_acc_ff[DATA_W+FRAC_W-1:FRAC_W];
      end else if (fin_acc_ff[ACC_W-1]) begin
         y_sat = Q_MIN;
      end else begin
         y_sat = Q_MAX;
      end
   end

   assign out_load     = fin_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign rsp_valid_in = out_load | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         fin_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
         clip_ff      <= 1'b0;
         col_ff       <= '0;
      end else begin
         if (advance) begin
            s1_valid_ff  <= accept & req_func;
            s2_valid_ff  <= s1_valid_ff;
            fin_valid_ff <= s2_valid_ff & s2_end_ff;
         end
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
         clip_ff      <= clip_in;
         col_ff       <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_in_range_ff <= in_range;
         s1_has_ff      <= req_has_entry;
         s1_start_ff    <= req_column_start;
         s1_end_ff      <= req_column_end;
         s1_val_ff      <= req_entry_value;
         s1_init_ff     <= req_initial_y;
         s2_has_ff      <= s1_has_ff;
         s2_start_ff    <= s1_start_ff;
         s2_end_ff      <= s1_end_ff;
         s2_init_ff     <= s1_init_ff;
         s2_prod_ff     <= s2_prod_in;
         fin_acc_ff     <= acc_new;
         fin_clip_ff    <= clip_new;
         fin_col_ff     <= col_ff;
      end
      if (out_load) begin
         rsp_y_ff   <= y_sat;
         rsp_col_ff <= fin_col_ff;
         rsp_sat_ff <= fin_clip_ff | ~fits;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_y_value       = rsp_y_ff;
   assign rsp_column_number = rsp_col_ff;
   assign rsp_saturated     = rsp_sat_ff;

endmodule

>>> rtl/stmva_chk.sv
// Port-level checker for the sparse transpose matvec block, with its bind.
module stmva_chk (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [stmva_pkg::DATA_W-1:0] rsp_y_value,
   input logic [stmva_pkg::COL_W-1:0]         rsp_column_number,
   input logic                                rsp_saturated
);

   import stmva_pkg::*;

   logic [COL_W-1:0] next_col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         next_col_ff <= '0;
      end else if (rsp_valid & rsp_ready) begin
         next_col_ff <= rsp_column_number + 1'b1;
      end
   end

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_col_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_column_number == next_col_ff)
      else $error("column number out of sequence");

   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with no response waiting");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_y_value) &&
      $stable(rsp_column_number) && $stable(rsp_saturated))
      else $error("stalled response changed");

endmodule

bind sparse_transpose_matvec_accumulate stmva_chk u_stmva_chk (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_y_value       (rsp_y_value),
   .rsp_column_number (rsp_column_number),
   .rsp_saturated     (rsp_saturated)
);
